@@ sv/modular_exponentiation_top_assert.svh @@
// Assertion helpers shared by the modular exponentiation RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MODULAR_EXPONENTIATION_TOP_ASSERT_SVH
`define MODULAR_EXPONENTIATION_TOP_ASSERT_SVH

// Same-cycle implication.
`define MEXP_CHK_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define MEXP_CHK_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ sv/mexp_pkg.sv @@
`timescale 1ns / 1ps

package mexp_pkg;

  typedef logic [2:0] step_t;

  localparam step_t ST_IDLE  = 3'd0;
  localparam step_t ST_CHKM  = 3'd1;
  localparam step_t ST_RED   = 3'd2;
  localparam step_t ST_BIT   = 3'd3;
  localparam step_t ST_MRES  = 3'd4;
  localparam step_t ST_MSQR  = 3'd5;
  localparam step_t ST_SHIFT = 3'd6;
  localparam step_t ST_EMIT  = 3'd7;

  // What a step waits for before it may leave.
  typedef enum logic [1:0] {
    W_NONE = 2'd0,
    W_IN   = 2'd1,
    W_MUL  = 2'd2,
    W_OUT  = 2'd3
  } wait_t;

  // Jump condition, tested when the step leaves.
  typedef enum logic [2:0] {
    J_NEVER   = 3'd0,
    J_ALWAYS  = 3'd1,
    J_MZERO   = 3'd2,
    J_BIT_CLR = 3'd3,
    J_MORE    = 3'd4
  } jump_t;

  // Datapath action of a step.
  typedef enum logic [2:0] {
    A_NONE  = 3'd0,
    A_LOAD  = 3'd1,
    A_RED   = 3'd2,
    A_MRES  = 3'd3,
    A_MSQR  = 3'd4,
    A_SHIFT = 3'd5,
    A_EMIT  = 3'd6
  } act_t;

  typedef struct packed {
    wait_t wt;
    jump_t jc;
    step_t target;
    act_t  act;
  } ucw_t;

  // Status from the serial modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

  // Control store: one word per step.
  function automatic ucw_t mexp_ucode(step_t s);
    ucw_t w;
    w = '{wt: W_NONE, jc: J_NEVER, target: ST_IDLE, act: A_NONE};
    unique case (s)
      ST_IDLE:  w = '{wt: W_IN,   jc: J_NEVER,   target: ST_IDLE, act: A_LOAD};
      ST_CHKM:  w = '{wt: W_NONE, jc: J_MZERO,   target: ST_EMIT, act: A_NONE};
      ST_RED:   w = '{wt: W_MUL,  jc: J_NEVER,   target: ST_IDLE, act: A_RED};
      ST_BIT:   w = '{wt: W_NONE, jc: J_BIT_CLR, target: ST_MSQR, act: A_NONE};
      ST_MRES:  w = '{wt: W_MUL,  jc: J_NEVER,   target: ST_IDLE, act: A_MRES};
      ST_MSQR:  w = '{wt: W_MUL,  jc: J_NEVER,   target: ST_IDLE, act: A_MSQR};
      ST_SHIFT: w = '{wt: W_NONE, jc: J_MORE,    target: ST_BIT,  act: A_SHIFT};
      ST_EMIT:  w = '{wt: W_OUT,  jc: J_ALWAYS,  target: ST_IDLE, act: A_EMIT};
    endcase
    return w;
  endfunction

endpackage

@@ sv/mexp_mulmod.sv @@
`timescale 1ns / 1ps

module mexp_mulmod import mexp_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] m,
  output mm_stat_t         stat,
  output logic [WIDTH-1:0] product
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] x_r;
  logic [WIDTH-1:0] y_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [WIDTH:0] mx, dbl, dbl_red, addend, sum, sum_red;

  // One step: double, reduce, conditionally add x, reduce.
  always_comb begin
    mx      = {1'b0, m};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= mx) ? (dbl - mx) : dbl;
    addend  = y_r[WIDTH-1] ? {1'b0, x_r} : '0;
    sum     = dbl_red + addend;
    sum_red = (sum >= mx) ? (sum - mx) : sum;
    acc_nxt = sum_red[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      x_r   <= x;
      y_r   <= y;
      cnt_r <= CW'(WIDTH - 1);
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      y_r   <= {y_r[WIDTH-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

endmodule

@@ sv/modular_exponentiation_top.sv @@
`timescale 1ns / 1ps
// Modular exponentiation: out_power_mod = in_base ** in_exponent mod modulus.
// Input channel: in_valid / in_stall with in_base and in_exponent; a
//   transaction is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with out_power_mod, held in an
//   output register while out_stall is high.
// Configuration: cfg_we writes cfg_wdata into the modulus; write it only
//   while no transaction is in flight. Modulus zero yields zero.
// One transaction is worked at a time; in_stall drops only when the
//   sequencer sits in its idle step. A pending result does not block
//   the next transaction from being taken and worked.
// Per transaction the sequencer reduces the base, then for every exponent bit
//   multiplies the result by the base when the bit is set and squares the base;
//   modulus zero goes straight to the emit step. Each modular multiply is
//   launched, runs one bit a cycle through the serial multiplier and reports done.
//   After the edge that raises out_valid, the next transaction is taken in the
//   following cycle at the earliest.
// Reset (rst_n low at a clock edge) sets the modulus to 1, empties the
//   output register and returns the sequencer to its idle step.
// While out_stall holds a result, the block finishes its current work and
//   waits in its emit step until the output register frees.
module modular_exponentiation_top import mexp_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] in_base,
  input  logic [WIDTH-1:0] in_exponent,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_power_mod,
  input  logic             cfg_we,
  input  logic [WIDTH-1:0] cfg_wdata
);

  localparam int BCW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [BCW-1:0] LAST_BIT = BCW'(WIDTH - 1);
  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  // Sequencer and datapath registers
  step_t            step_r, step_nxt;
  logic [WIDTH-1:0] m_r;
  logic [WIDTH-1:0] pw_r;
  logic [WIDTH-1:0] res_r;
  logic [WIDTH-1:0] e_r;
  logic [BCW-1:0]   bit_cnt_r;
  logic             launched_r;
  logic             out_valid_r;
  logic [WIDTH-1:0] out_power_mod_r;

  ucw_t             uc;
  logic             go;
  logic             jump;
  logic             is_mul;
  logic             mul_start;
  logic [WIDTH-1:0] mul_x, mul_y, mul_p;
  mm_stat_t         mst;

  // Fetch the control word of the current step.
  assign uc = mexp_ucode(step_r);

  // Leave the step once its wait condition is met.
  always_comb begin
    unique case (uc.wt)
      W_NONE: go = 1'b1;
      W_IN:   go = in_valid;
      W_MUL:  go = mst.done;
      W_OUT:  go = !out_valid_r || !out_stall;
    endcase
  end

  always_comb begin
    unique case (uc.jc)
      J_NEVER:   jump = 1'b0;
      J_ALWAYS:  jump = 1'b1;
      J_MZERO:   jump = (m_r == '0);
      J_BIT_CLR: jump = !e_r[0];
      J_MORE:    jump = (bit_cnt_r != LAST_BIT);
      default:   jump = 1'b0;
    endcase
  end

  assign step_nxt = !go ? step_r : (jump ? uc.target : step_r + 3'd1);

  // Pick multiplier operands; reduction of the base is 1 * base mod m.
  assign is_mul = (uc.act == A_RED) || (uc.act == A_MRES) || (uc.act == A_MSQR);
  assign mul_start = is_mul && !launched_r;

  always_comb begin
    priority case (uc.act)
      A_RED:   begin mul_x = ONE;   mul_y = pw_r; end
      A_MRES:  begin mul_x = res_r; mul_y = pw_r; end
      default: begin mul_x = pw_r;  mul_y = pw_r; end
    endcase
  end

  mexp_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .x       (mul_x),
    .y       (mul_y),
    .m       (m_r),
    .stat    (mst),
    .product (mul_p)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      m_r         <= ONE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (cfg_we) begin
        m_r <= cfg_wdata;
      end
      // Track an issued multiply until it reports done.
      if (mul_start) begin
        launched_r <= 1'b1;
      end else if (mst.done) begin
        launched_r <= 1'b0;
      end
      // Hold the result until the receiver takes it.
      if ((uc.act == A_EMIT) && go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (uc.act)
      A_LOAD: begin
        if (go) begin
          pw_r      <= in_base;
          e_r       <= in_exponent;
          res_r     <= {{(WIDTH-1){1'b0}}, (m_r > ONE)};
          bit_cnt_r <= '0;
        end
      end
      A_RED, A_MSQR: begin
        if (go) begin
          pw_r <= mul_p;
        end
      end
      A_MRES: begin
        if (go) begin
          res_r <= mul_p;
        end
      end
      A_SHIFT: begin
        e_r       <= {1'b0, e_r[WIDTH-1:1]};
        bit_cnt_r <= bit_cnt_r + 1'b1;
      end
      A_EMIT: begin
        if (go) begin
          out_power_mod_r <= res_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Take a transaction only in the idle step.
  assign in_stall      = (uc.wt != W_IN);
  assign out_valid     = out_valid_r;
  assign out_power_mod = out_power_mod_r;

  `include "modular_exponentiation_top_assert.svh"

  `MEXP_CHK_IMP(a_start_idle, mul_start, !mst.busy, "multiply issued while unit busy")
  `MEXP_CHK_IMP(a_done_in_mul, mst.done, is_mul && launched_r, "multiply done outside a mul step")
  `MEXP_CHK_NXT(a_accept_next, (step_r == ST_IDLE) && in_valid, step_r == ST_CHKM,
    "accepted transaction did not advance the sequencer")

endmodule

@@ test/tb_modular_exponentiation_top.sv @@
`timescale 1ns / 1ps

// Power-mod checker. Directed operands cover the corners; random phases
// cover the modulus range. Each phase reloads the modulus while the block
// is drained.
module tb_modular_exponentiation_top;

  localparam int W          = 32;
  localparam int QUIET_MAX  = 50000;  // cycles with no transaction before we give up
  localparam int PRESS_HOLD = 8000;   // long receiver hold-off, spans several items
  localparam int SETTLE     = 16;     // emit is the last step, a few cycles suffice

  typedef struct {
    logic [W-1:0] base;
    logic [W-1:0] exponent;
  } operand_pair_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [W-1:0] in_base = '0;
  logic [W-1:0] in_exponent = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [W-1:0] out_power_mod;
  logic         cfg_we = 1'b0;
  logic [W-1:0] cfg_wdata = '0;

  // Stimulus and scoreboard state.
  operand_pair_t pending_ops[$];
  logic [W-1:0]  power_q[$];       // expected power_mod values, oldest first
  logic [W-1:0]  modulus_now = 1;  // mirror of the modulus register
  logic [W-1:0]  want;
  operand_pair_t next_op;
  logic          in_took = 1'b0;
  int            send_gap = 0;
  int            stall_left = 0;
  int            press_left = 0;
  logic          press_on = 1'b0;
  logic          press_done = 1'b0;
  logic          no_idle = 1'b0;
  int            quiet_cycles = 0;
  int            errors = 0;

  always #6 clk = ~clk;

  modular_exponentiation_top #(.WIDTH(W)) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_base      (in_base),
    .in_exponent  (in_exponent),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_power_mod(out_power_mod),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // Right-to-left square-and-multiply. Both factors stay below the modulus,
  // so a 64-bit product never overflows.
  function automatic logic [W-1:0] power_mod_of(logic [W-1:0] b, logic [W-1:0] e,
                                                logic [W-1:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] m64;
    if (m == '0) return '0;
    m64 = {32'b0, m};
    sq  = {32'b0, b} % m64;
    acc = 64'd1 % m64;
    for (int i = 0; i < W; i++) begin
      if (e[i]) acc = (acc * sq) % m64;
      sq = (sq * sq) % m64;
    end
    return acc[W-1:0];
  endfunction

  // Idle length: mostly none or short, now and then a long one.
  function automatic int gap_cycles();
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 1500);
    return $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
  endfunction

  // Driver: advance to the next transaction once the current one is taken,
  // hold the payload while the block stalls.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        next_op = pending_ops.pop_front();
        in_valid    <= 1'b1;
        in_base     <= next_op.base;
        in_exponent <= next_op.exponent;
        send_gap    <= no_idle ? 0 : gap_cycles();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block fills up
  // with a parked result and a finished second one, and stalls its input.
  always @(negedge clk) begin
    if (rst_n) begin
      if (press_on && !press_done) begin
        press_done <= 1'b1;
        press_left <= PRESS_HOLD;
        out_stall  <= 1'b1;
      end else if (press_left > 0) begin
        press_left <= press_left - 1;
        out_stall  <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left <= gap_cycles();
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predict on each input transaction, check each output
  // transaction against the oldest prediction, and watch for a hang.
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall)
        power_q.insert(power_q.size(), power_mod_of(in_base, in_exponent, modulus_now));
      if (out_valid && !out_stall) begin
        if (power_q.size() == 0) begin
          $display("%0t: power_mod expected none, actual %h", $time, out_power_mod);
          errors++;
        end else begin
          want = power_q.pop_front();
          if (out_power_mod !== want) begin
            $display("%0t: power_mod expected %h, actual %h", $time, want, out_power_mod);
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic queue_pair(input logic [W-1:0] b, input logic [W-1:0] e);
    operand_pair_t op;
    op.base     = b;
    op.exponent = e;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  // Write the modulus while the block is idle, then step past the write.
  task automatic load_modulus(input logic [W-1:0] m);
    @(negedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= m;
    modulus_now <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every queued transaction went in and every result came out.
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_ops.size() != 0 || in_valid || power_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random operands: mostly full-range, with small values, values near the
  // modulus and sparse or dense exponents mixed in.
  task automatic queue_random_pairs(input int count, input logic [W-1:0] m);
    logic [W-1:0] b;
    logic [W-1:0] e;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 5))
        0:       b = $urandom_range(0, 15);
        1:       b = m - $urandom_range(0, 2);
        2:       b = m + $urandom_range(0, 2);
        default: b = $urandom();
      endcase
      case ($urandom_range(0, 7))
        0:       e = $urandom_range(0, 8);
        1:       e = '1;
        2:       e = {{(W-1){1'b0}}, 1'b1} << $urandom_range(0, W-1);
        3:       e = ~({{(W-1){1'b0}}, 1'b1} << $urandom_range(0, W-1));
        default: e = $urandom();
      endcase
      queue_pair(b, e);
    end
  endtask

  initial begin
    logic [W-1:0] m;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Modulus one straight out of reset: everything reduces to zero.
    queue_pair('1, '1);
    queue_pair('0, '0);
    drain();

    // Largest modulus: exponent zero, zero base, base equal to the modulus,
    // minus one raised to odd and even powers, powers of two.
    load_modulus('1);
    queue_pair('0, '0);
    queue_pair('0, 32'd1);
    queue_pair('0, '1);
    queue_pair('1, '0);
    queue_pair('1, '1);
    queue_pair(32'hFFFF_FFFE, 32'd2);
    queue_pair(32'hFFFF_FFFE, '1);
    queue_pair(32'd2, 32'd31);
    queue_pair(32'd2, 32'd32);
    queue_pair(32'h1234_5678, 32'd1);
    drain();

    // Prime modulus: Fermat's little theorem gives one for the exponent modulus minus one.
    load_modulus(32'hFFFF_FFFB);
    queue_pair(32'hFFFF_FFFA, 32'hFFFF_FFFA);
    queue_pair(32'd3, 32'hFFFF_FFFA);
    queue_pair('1, '1);
    drain();

    // Modulus zero: result pinned at zero.
    load_modulus('0);
    queue_pair('1, '1);
    queue_pair(32'd5, 32'd3);
    queue_pair('0, '0);
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       m = '1;
        1:       m = 32'hFFFF_FFFB;
        2:       m = '0;
        3:       m = 32'd1;
        4:       m = 32'd2;
        5:       m = 32'h0001_0001;
        6:       m = 32'h8000_0000;
        7:       m = $urandom_range(3, 65535);
        default: m = $urandom();
      endcase
      load_modulus(m);
      press_on <= (p == 5);
      no_idle  <= (p == 6);
      queue_random_pairs((m < 2) ? 10 : 30, m);
      drain();
    end

    drain();
    if (errors == 0 && power_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
